FILE: design/affine_transform_composer_assert.svh
// Assertion macros used by the composer controller.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef AFFINE_TRANSFORM_COMPOSER_ASSERT_SVH
`define AFFINE_TRANSFORM_COMPOSER_ASSERT_SVH

// Checks an implication on every clock edge outside reset.
`define ATC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define ATC_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

FILE: design/atc_pkg.sv
// Shared types, constants and tables for the affine transform composer.
// Used by the controller, the datapath and the top level; depends on nothing.
package atc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int MAX_STEPS    = 30;
  localparam int CORDIC_N     = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int ITER_W       = $clog2(CORDIC_N);
  localparam int CNT_W        = (ITER_W > 3) ? ITER_W : 3;

  localparam logic signed [31:0] ONE_Q16   = 32'sd65536;
  localparam logic        [32:0] FULL_DEG  = 33'd23592960;
  localparam logic signed [26:0] FULL_S    = 27'sd23592960;
  localparam logic signed [26:0] HALF_S    = 27'sd11796480;
  localparam logic signed [26:0] QUARTER_S = 27'sd5898240;
  localparam logic signed [33:0] GAIN =
    34'(64'd652032874 + (64'd434688583 >> (2 * CORDIC_N)));

  typedef enum logic [2:0] {
    OP_ROTATE      = 3'd0,
    OP_FLIP        = 3'd1,
    OP_SCALE       = 3'd2,
    OP_TRANSLATE   = 3'd3,
    OP_SHEAR       = 3'd4,
    OP_PERSPECTIVE = 3'd5
  } atc_op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RED, ST_FOLD, ST_CORD, ST_ROUND, ST_MAC, ST_DRAIN, ST_COMMIT
  } atc_state_t;

  typedef struct packed {
    logic              load;
    logic              red_step;
    logic [2:0]        red_sh;
    logic              fold;
    logic              cordic_step;
    logic [ITER_W-1:0] iter;
    logic              round;
    logic              mac_issue;
    logic [1:0]        row;
    logic [1:0]        col;
    logic [1:0]        kk;
    logic              commit;
  } atc_cmd_t;

  // Arctangent of 2^-i in units of 2^-24 degree.
  function automatic logic signed [33:0] atan_deg24(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sd754974720;
      5'd1:  v = 34'sd445687602;
      5'd2:  v = 34'sd235489088;
      5'd3:  v = 34'sd119537938;
      5'd4:  v = 34'sd60000934;
      5'd5:  v = 34'sd30029717;
      5'd6:  v = 34'sd15018523;
      5'd7:  v = 34'sd7509720;
      5'd8:  v = 34'sd3754917;
      5'd9:  v = 34'sd1877466;
      5'd10: v = 34'sd938734;
      5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;
      5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;
      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;
      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;
      5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;
      5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;
      5'd23: v = 34'sd115;
      5'd24: v = 34'sd57;
      5'd25: v = 34'sd29;
      5'd26: v = 34'sd14;
      5'd27: v = 34'sd7;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/atc_ctrl.sv
// Sequencer for the composer: angle reduction, CORDIC, multiply-accumulate and commit.
// Depends on atc_pkg and the assertion macro header.
`include "affine_transform_composer_assert.svh"

module atc_ctrl
  import atc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_operation,
  output logic       out_valid,
  input  logic       out_ready,
  output atc_cmd_t   cmd
);

  atc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       row_r, row_nxt, col_r, col_nxt, kk_r, kk_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      kk_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      kk_r        <= kk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    kk_nxt    = kk_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.red_sh = cnt_r[2:0];
    cmd.iter   = cnt_r[ITER_W-1:0];
    cmd.row    = row_r;
    cmd.col    = col_r;
    cmd.kk     = kk_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          row_nxt  = '0;
          col_nxt  = '0;
          kk_nxt   = '0;
          if (atc_op_t'(in_operation) == OP_ROTATE) begin
            state_nxt = ST_RED;
            cnt_nxt   = CNT_W'(7);
          end else begin
            state_nxt = ST_MAC;
          end
        end
      end
      ST_RED: begin
        cmd.red_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FOLD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_CORD;
      end
      ST_CORD: begin
        cmd.cordic_step = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_N - 1)) begin
          state_nxt = ST_ROUND;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac_issue = 1'b1;
        if (kk_r != 2'd2) begin
          kk_nxt = kk_r + 1'b1;
        end else begin
          kk_nxt = '0;
          if (col_r != 2'd2) begin
            col_nxt = col_r + 1'b1;
          end else begin
            col_nxt = '0;
            if (row_r != 2'd2) begin
              row_nxt = row_r + 1'b1;
            end else begin
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && !out_ready);
  end

  assign out_valid = out_valid_r;

  `ATC_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "accepted word did not start work")
  `ATC_ASSERT(a_commit_free, cmd.commit |-> (!out_valid_r || out_ready), "commit over pending result")
  `ATC_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid, "commit did not raise out_valid")
  `ATC_ASSERT(a_one_unit, cmd.mac_issue |-> !(cmd.cordic_step || cmd.red_step), "units overlap")

endmodule

FILE: design/atc_datapath.sv
// Datapath of the composer: angle reduction, CORDIC, shared multiplier and matrix store.
// Driven by atc_ctrl through atc_cmd_t; depends on atc_pkg.
module atc_datapath
  import atc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  atc_cmd_t           cmd,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_param_a,
  input  logic signed [31:0] in_param_b,
  input  logic               in_flip_x,
  input  logic               in_flip_y,
  output logic signed [31:0] mat [9],
  output logic               sat
);

  atc_op_t            op_r;
  logic signed [31:0] a_r, b_r, cs_r, sn_r;
  logic               fx_r, fy_r, aneg_r, neg_r, sat_r, sat_out_r;
  logic        [32:0] mag_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic signed [31:0] mat_r [9];
  logic signed [31:0] res_r [9];
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r;
  logic               mv_r, mfirst_r, mlast_r;
  logic        [3:0]  dst_r;

  function automatic logic signed [31:0] e_val(
    input atc_op_t op, input logic [1:0] row, input logic [1:0] kk,
    input logic signed [31:0] a, input logic signed [31:0] b,
    input logic fx, input logic fy,
    input logic signed [31:0] cs, input logic signed [31:0] sn);
    logic signed [31:0] v;
    v = (row == kk) ? ONE_Q16 : 32'sd0;
    case (op)
      OP_ROTATE: begin
        if (row == 2'd0 && kk == 2'd0) v = cs;
        if (row == 2'd0 && kk == 2'd1) v = -sn;
        if (row == 2'd1 && kk == 2'd0) v = sn;
        if (row == 2'd1 && kk == 2'd1) v = cs;
      end
      OP_FLIP: begin
        if (row == 2'd0 && kk == 2'd0 && fx) v = -ONE_Q16;
        if (row == 2'd1 && kk == 2'd1 && fy) v = -ONE_Q16;
      end
      OP_SCALE: begin
        if (row == 2'd0 && kk == 2'd0) v = a;
        if (row == 2'd1 && kk == 2'd1) v = b;
      end
      OP_TRANSLATE: begin
        if (row == 2'd0 && kk == 2'd2) v = a;
        if (row == 2'd1 && kk == 2'd2) v = b;
      end
      OP_SHEAR: begin
        if (row == 2'd0 && kk == 2'd1) v = a;
        if (row == 2'd1 && kk == 2'd0) v = b;
      end
      OP_PERSPECTIVE: begin
        if (row == 2'd2 && kk == 2'd0) v = a;
        if (row == 2'd2 && kk == 2'd1) v = b;
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  logic        [32:0] red_sub;
  logic signed [26:0] rem_s, r0, r1, r2;
  logic               fneg;
  logic signed [33:0] dx, dy, xs, ys;
  logic        [3:0]  t_idx;
  logic signed [31:0] e_cur;
  logic signed [65:0] sum;
  logic signed [49:0] rnd;
  logic signed [31:0] clamp;
  logic               clamp_hit;

  always_comb begin
    red_sub = FULL_DEG << cmd.red_sh;
    rem_s   = 27'(mag_r);
    r0      = (aneg_r && rem_s != '0) ? (FULL_S - rem_s) : rem_s;
    r1      = (r0 > HALF_S) ? (r0 - FULL_S) : r0;
    fneg    = 1'b0;
    r2      = r1;
    if (r1 > QUARTER_S) begin
      r2   = r1 - HALF_S;
      fneg = 1'b1;
    end else if (r1 < -QUARTER_S) begin
      r2   = r1 + HALF_S;
      fneg = 1'b1;
    end
    dx = y_r >>> cmd.iter;
    dy = x_r >>> cmd.iter;
    xs = neg_r ? -x_r : x_r;
    ys = neg_r ? -y_r : y_r;
    t_idx = {2'b00, cmd.kk} * 4'd3 + {2'b00, cmd.col};
    e_cur = e_val(op_r, cmd.row, cmd.kk, a_r, b_r, fx_r, fy_r, cs_r, sn_r);
    sum   = mfirst_r ? 66'(prod_r) : (acc_r + 66'(prod_r));
    rnd   = 50'((sum + 66'sd32768) >>> 16);
    clamp_hit = 1'b0;
    clamp     = rnd[31:0];
    if (rnd > 50'sd2147483647) begin
      clamp     = 32'sh7fffffff;
      clamp_hit = 1'b1;
    end else if (rnd < -50'sd2147483648) begin
      clamp     = 32'sh80000000;
      clamp_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= atc_op_t'(in_operation);
      a_r    <= in_param_a;
      b_r    <= in_param_b;
      fx_r   <= in_flip_x;
      fy_r   <= in_flip_y;
      aneg_r <= in_param_a[31];
      mag_r  <= in_param_a[31] ? (33'd0 - 33'(in_param_a)) : 33'(in_param_a);
    end
    if (cmd.red_step && mag_r >= red_sub) begin
      mag_r <= mag_r - red_sub;
    end
    if (cmd.fold) begin
      z_r   <= 34'(r2) <<< 8;
      x_r   <= GAIN;
      y_r   <= '0;
      neg_r <= fneg;
    end
    if (cmd.cordic_step) begin
      if (!z_r[33]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_deg24(5'(cmd.iter));
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_deg24(5'(cmd.iter));
      end
    end
    if (cmd.round) begin
      cs_r <= 32'((xs + 34'sd8192) >>> 14);
      sn_r <= 32'((ys + 34'sd8192) >>> 14);
    end
    if (cmd.mac_issue) begin
      prod_r   <= e_cur * mat_r[t_idx];
      mfirst_r <= (cmd.kk == 2'd0);
      mlast_r  <= (cmd.kk == 2'd2);
      dst_r    <= {2'b00, cmd.row} * 4'd3 + {2'b00, cmd.col};
    end
    if (mv_r) begin
      acc_r <= sum;
      if (mlast_r) begin
        res_r[dst_r] <= clamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r      <= 1'b0;
      sat_r     <= 1'b0;
      sat_out_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        mat_r[i] <= (i % 4 == 0) ? ONE_Q16 : 32'sd0;
      end
    end else begin
      mv_r <= cmd.mac_issue;
      if (cmd.load) begin
        sat_r <= 1'b0;
      end else if (mv_r && mlast_r && clamp_hit) begin
        sat_r <= 1'b1;
      end
      if (cmd.commit) begin
        mat_r     <= res_r;
        sat_out_r <= sat_r;
      end
    end
  end

  assign mat = mat_r;
  assign sat = sat_out_r;

endmodule

FILE: design/affine_transform_composer.sv
// Top level of the affine transform composer: joins atc_ctrl and atc_datapath.
// Depends on atc_pkg.
//
// Keeps a 3x3 homogeneous transform in Q16.16, reset to identity, and premultiplies it by
// one elementary matrix (rotate, flip, scale, translate, shear or perspective) per input
// word, returning all nine new entries with a flag that is set when any entry saturated.
// The nine entries come from one shared 32x32 multiplier, one product per cycle, 27 in all.
// After the products come a drain state and a commit state, which waits while an earlier
// result is still held on the output; the next word can be taken after the commit. Rotate
// first reduces the angle in 8 compare-subtract steps, folds it and runs a 16-step CORDIC
// plus a rounding step before the products. One word is worked on at a time; the next
// word is taken while the previous result still waits on the output.
module affine_transform_composer
  import atc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_param_a,
  input  logic signed [31:0] in_param_b,
  input  logic               in_flip_x,
  input  logic               in_flip_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_m00,
  output logic signed [31:0] out_m01,
  output logic signed [31:0] out_m02,
  output logic signed [31:0] out_m10,
  output logic signed [31:0] out_m11,
  output logic signed [31:0] out_m12,
  output logic signed [31:0] out_m20,
  output logic signed [31:0] out_m21,
  output logic signed [31:0] out_m22,
  output logic               out_saturated
);

  atc_cmd_t           cmd;
  logic signed [31:0] mat [9];

  atc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd)
  );

  atc_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_operation (in_operation),
    .in_param_a   (in_param_a),
    .in_param_b   (in_param_b),
    .in_flip_x    (in_flip_x),
    .in_flip_y    (in_flip_y),
    .mat          (mat),
    .sat          (out_saturated)
  );

  assign out_m00 = mat[0];
  assign out_m01 = mat[1];
  assign out_m02 = mat[2];
  assign out_m10 = mat[3];
  assign out_m11 = mat[4];
  assign out_m12 = mat[5];
  assign out_m20 = mat[6];
  assign out_m21 = mat[7];
  assign out_m22 = mat[8];

endmodule
